/* rtl/core/gwc_pkg.sv */
package gwc_pkg;

  localparam int unsigned LenW  = 32;
  localparam int unsigned NodeW = 3;
  localparam int unsigned ResW  = 30;
  localparam int unsigned AdjW  = 64;

  // Adjacency bit of row i, column j sits at i*RowStride+j.
  localparam int unsigned RowStride = 8;

  localparam int unsigned NodeCountDef = 8;
  localparam int unsigned ExpBitsDef   = 32;

  localparam logic [ResW-1:0] Mod = 30'd1000000007;

  // Barrett factor floor(2^60 / Mod); fits in 31 bits.
  localparam logic [63:0] BarrettFull = (64'd1 << 60) / 64'd1000000007;
  localparam logic [30:0] BarrettM    = BarrettFull[30:0];

  localparam logic [AdjW-1:0] AdjReset = 64'h5CA6418894CA4522;

  typedef struct packed {
    logic [LenW-1:0]  walk_length;
    logic [NodeW-1:0] start_node;
    logic [NodeW-1:0] end_node;
  } query_t;

endpackage

/* rtl/core/gwc_mulmod.sv */
// Pipelined modular multiplier: r = a*b mod Mod, one product per cycle.
module gwc_mulmod #(
  parameter int TagW = 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic [gwc_pkg::ResW-1:0] a_i,
  input  logic [gwc_pkg::ResW-1:0] b_i,
  input  logic [TagW-1:0]          tag_i,
  output logic                     out_valid_o,
  output logic [TagW-1:0]          out_tag_o,
  output logic [gwc_pkg::ResW-1:0] r_o
);

  localparam int Stages = 5;

  logic [Stages-1:0] vld_q;
  logic [TagW-1:0]   tag_q [Stages];

  logic [59:0] p1_q;
  logic [60:0] th2_q, tl2_q;
  logic [31:0] plo2_q, plo3_q, plo4_q;
  logic [29:0] q3_q;
  logic [31:0] qp4_q;
  logic [29:0] r5_q;
  logic [60:0] qsum;
  logic [31:0] diff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Stages-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q[0] <= tag_i;
    for (int i = 1; i < Stages; i++) begin
      tag_q[i] <= tag_q[i-1];
    end
  end

  // The quotient estimate is never above the true one and at most one below it.
  assign qsum = th2_q + (tl2_q >> 30);
  assign diff = plo4_q - qp4_q;

  always_ff @(posedge clk_i) begin
    p1_q   <= 60'(a_i) * 60'(b_i);
    th2_q  <= 61'(p1_q[59:30]) * 61'(gwc_pkg::BarrettM);
    tl2_q  <= 61'(p1_q[29:0]) * 61'(gwc_pkg::BarrettM);
    plo2_q <= p1_q[31:0];
    q3_q   <= qsum[59:30];
    plo3_q <= plo2_q;
    qp4_q  <= 32'(q3_q) * 32'(gwc_pkg::Mod);
    plo4_q <= plo3_q;
    r5_q   <= (diff >= 32'(gwc_pkg::Mod)) ? 30'(diff - 32'(gwc_pkg::Mod)) : diff[29:0];
  end

  assign out_valid_o = vld_q[Stages-1];
  assign out_tag_o   = tag_q[Stages-1];
  assign r_o         = r5_q;

endmodule

/* rtl/core/gwc_engine.sv */
module gwc_engine #(
  parameter int NODE_COUNT    = gwc_pkg::NodeCountDef,
  parameter int EXPONENT_BITS = gwc_pkg::ExpBitsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  gwc_pkg::query_t          query_i,
  input  logic [gwc_pkg::AdjW-1:0] adj_i,
  output logic                     idle_o,
  output logic                     res_valid_o,
  input  logic                     res_ready_i,
  output logic [gwc_pkg::ResW-1:0] res_data_o
);

  localparam int Depth = NODE_COUNT * NODE_COUNT;
  localparam int AddrW = $clog2(Depth);
  localparam int IdxW  = $clog2(NODE_COUNT);
  localparam int BcW   = $clog2(EXPONENT_BITS + 1);
  localparam logic [IdxW-1:0] IdxMax = IdxW'(NODE_COUNT - 1);

  typedef enum logic [2:0] {
    StIdle, StInit, StStep, StMul, StDrain, StCopy, StFin, StOut
  } state_e;

  typedef struct packed {
    logic             first;
    logic             last;
    logic             tail;
    logic [AddrW-1:0] waddr;
  } tag_t;

  localparam int TagW = $bits(tag_t);

  state_e                     state_q;
  logic [IdxW-1:0]            r_q, c_q, k_q;
  logic [gwc_pkg::LenW-1:0]   exp_q;
  logic [BcW-1:0]             bcnt_q;
  logic                       sq_q, sel_res_q;
  logic [gwc_pkg::NodeW-1:0]  src_q, dst_q;

  logic [29:0] pow_mem [Depth];
  logic [29:0] res_mem [Depth];
  logic [29:0] scr_mem [Depth];

  logic [AddrW-1:0] addr_x, addr_y, addr_rc, fin_addr, res_rd_addr;
  logic [29:0]      res_rd_q, pow_rd_a_q, pow_rd_b_q, scr_rd_q;
  logic             rc_last, mul_last, node_ok;
  logic [5:0]       adj_idx;

  logic             iss_vld_q;
  tag_t             iss_tag, iss_tag_q;
  logic             mm_vld;
  logic [TagW-1:0]  mm_tag_raw;
  tag_t             mm_tag;
  logic [29:0]      mm_r;
  logic [29:0]      acc_q;
  logic [30:0]      sum;
  logic [29:0]      sum_mod;
  logic             tail_done;

  logic             cp_we_q;
  logic [AddrW-1:0] cp_addr_q;

  assign addr_x   = AddrW'(int'(r_q) * NODE_COUNT + int'(k_q));
  assign addr_y   = AddrW'(int'(k_q) * NODE_COUNT + int'(c_q));
  assign addr_rc  = AddrW'(int'(r_q) * NODE_COUNT + int'(c_q));
  assign fin_addr = AddrW'(int'(src_q) * NODE_COUNT + int'(dst_q));
  assign node_ok  = (int'(src_q) < NODE_COUNT) && (int'(dst_q) < NODE_COUNT);
  assign adj_idx  = 6'(int'(r_q) * gwc_pkg::RowStride + int'(c_q));
  assign rc_last  = (r_q == IdxMax) && (c_q == IdxMax);
  assign mul_last = rc_last && (k_q == IdxMax);

  assign res_rd_addr = (state_q == StMul) ? addr_x : fin_addr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      r_q       <= '0;
      c_q       <= '0;
      k_q       <= '0;
      exp_q     <= '0;
      bcnt_q    <= '0;
      sq_q      <= 1'b0;
      sel_res_q <= 1'b0;
      src_q     <= '0;
      dst_q     <= '0;
    end else begin
      case (state_q)
        StIdle: begin
          if (start_i) begin
            exp_q   <= query_i.walk_length;
            src_q   <= query_i.start_node;
            dst_q   <= query_i.end_node;
            bcnt_q  <= '0;
            sq_q    <= 1'b0;
            r_q     <= '0;
            c_q     <= '0;
            state_q <= StInit;
          end
        end
        StInit, StCopy: begin
          if (c_q == IdxMax) begin
            c_q <= '0;
            r_q <= r_q + 1'b1;
          end else begin
            c_q <= c_q + 1'b1;
          end
          if (rc_last) begin
            r_q     <= '0;
            state_q <= StStep;
            if (state_q == StCopy && !sel_res_q) begin
              exp_q  <= exp_q >> 1;
              bcnt_q <= bcnt_q + 1'b1;
              sq_q   <= 1'b0;
            end
          end
        end
        StStep: begin
          r_q <= '0;
          c_q <= '0;
          k_q <= '0;
          if (sq_q) begin
            sel_res_q <= 1'b0;
            state_q   <= StMul;
          end else if (exp_q == '0 || bcnt_q == BcW'(EXPONENT_BITS)) begin
            state_q <= StFin;
          end else if (exp_q[0]) begin
            sel_res_q <= 1'b1;
            sq_q      <= 1'b1;
            state_q   <= StMul;
          end else begin
            sel_res_q <= 1'b0;
            state_q   <= StMul;
          end
        end
        StMul: begin
          if (k_q == IdxMax) begin
            k_q <= '0;
            if (c_q == IdxMax) begin
              c_q <= '0;
              r_q <= r_q + 1'b1;
            end else begin
              c_q <= c_q + 1'b1;
            end
          end else begin
            k_q <= k_q + 1'b1;
          end
          if (mul_last) begin
            r_q     <= '0;
            state_q <= StDrain;
          end
        end
        StDrain: begin
          if (tail_done) begin
            r_q     <= '0;
            c_q     <= '0;
            state_q <= StCopy;
          end
        end
        StFin: state_q <= StOut;
        StOut: begin
          if (res_ready_i) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // Memory reads, registered.
  always_ff @(posedge clk_i) begin
    res_rd_q   <= res_mem[res_rd_addr];
    pow_rd_a_q <= pow_mem[addr_x];
    pow_rd_b_q <= pow_mem[addr_y];
    scr_rd_q   <= scr_mem[addr_rc];
  end

  // Copy-back writes land in the cycle after the scratch read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cp_we_q <= 1'b0;
    end else begin
      cp_we_q <= (state_q == StCopy);
    end
  end

  always_ff @(posedge clk_i) begin
    cp_addr_q <= addr_rc;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StInit) begin
      pow_mem[addr_rc] <= 30'(adj_i[adj_idx]);
    end else if (cp_we_q && !sel_res_q) begin
      pow_mem[cp_addr_q] <= scr_rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StInit) begin
      res_mem[addr_rc] <= 30'(r_q == c_q);
    end else if (cp_we_q && sel_res_q) begin
      res_mem[cp_addr_q] <= scr_rd_q;
    end
  end

  // Issue tags are registered so that they meet the registered memory read data.
  always_comb begin
    iss_tag.first = (k_q == '0);
    iss_tag.last  = (k_q == IdxMax);
    iss_tag.tail  = mul_last;
    iss_tag.waddr = addr_rc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iss_vld_q <= 1'b0;
    end else begin
      iss_vld_q <= (state_q == StMul);
    end
  end

  always_ff @(posedge clk_i) begin
    iss_tag_q <= iss_tag;
  end

  gwc_mulmod #(
    .TagW(TagW)
  ) u_mulmod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (iss_vld_q),
    .a_i        (sel_res_q ? res_rd_q : pow_rd_a_q),
    .b_i        (pow_rd_b_q),
    .tag_i      (iss_tag_q),
    .out_valid_o(mm_vld),
    .out_tag_o  (mm_tag_raw),
    .r_o        (mm_r)
  );

  assign mm_tag    = tag_t'(mm_tag_raw);
  assign sum       = 31'(mm_tag.first ? 30'd0 : acc_q) + 31'(mm_r);
  assign sum_mod   = (sum >= 31'(gwc_pkg::Mod)) ? 30'(sum - 31'(gwc_pkg::Mod)) : sum[29:0];
  assign tail_done = mm_vld && mm_tag.tail;

  always_ff @(posedge clk_i) begin
    if (mm_vld) begin
      acc_q <= sum_mod;
      if (mm_tag.last) begin
        scr_mem[mm_tag.waddr] <= sum_mod;
      end
    end
  end

  assign idle_o      = (state_q == StIdle);
  assign res_valid_o = (state_q == StOut);
  assign res_data_o  = node_ok ? res_rd_q : '0;

endmodule

/* rtl/core/graph_walk_count_matrix_power_core.sv */
// Walk counter: number of walks of a given length between two nodes, modulo 1000000007.
// The slave stream carries one query item; the master stream returns one count item.
// The cfg channel writes the 64-bit adjacency register (row i, column j at bit i*8+j);
// it is always ready and must only be written while no query is in flight.
// An item fills the working matrices, then runs square-and-multiply over the
// exponent bits, least significant first. Each matrix product streams N*N*N
// multiply-accumulates through one five-stage modular multiplier, drains and
// copies the scratch matrix back. There is one product per exponent bit up to
// the highest set bit and one more per set bit: at most 64 products for 32
// exponent bits. One item is worked on at a time.
// s_axis_tready is high while the engine is idle. The finished count sits in an
// output register, so a new query may start while the master side stalls; a second
// count then waits in the engine until the output register is free.
// Reset restores the built-in graph and empties the output register.
module graph_walk_count_matrix_power_core #(
  parameter int NODE_COUNT    = gwc_pkg::NodeCountDef,
  parameter int EXPONENT_BITS = gwc_pkg::ExpBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // walk_length [31:0], start_node [34:32], end_node [37:35], zero [39:38]
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // walk_count [29:0], zero [31:30]
  output logic [31:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [63:0] cfg_data_i
);

  logic [gwc_pkg::AdjW-1:0] adj_q;
  gwc_pkg::query_t          query;
  logic                     eng_idle, res_valid, res_ready;
  logic [gwc_pkg::ResW-1:0] res_data;
  logic                     out_valid_q;
  logic [gwc_pkg::ResW-1:0] out_data_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      adj_q <= gwc_pkg::AdjReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      adj_q <= cfg_data_i;
    end
  end

  assign query.walk_length = s_axis_tdata[31:0];
  assign query.start_node  = s_axis_tdata[34:32];
  assign query.end_node    = s_axis_tdata[37:35];
  assign s_axis_tready     = eng_idle;

  gwc_engine #(
    .NODE_COUNT   (NODE_COUNT),
    .EXPONENT_BITS(EXPONENT_BITS)
  ) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (s_axis_tvalid && s_axis_tready),
    .query_i    (query),
    .adj_i      (adj_q),
    .idle_o     (eng_idle),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_data_o (res_data)
  );

  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_data_q <= res_data;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = 32'(out_data_q);

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("engine still idle after accepting an item");

  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[29:0] < gwc_pkg::Mod)
    else $error("walk count not reduced");

  a_result_only_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> !eng_idle)
    else $error("result offered by an idle engine");

endmodule
